[design/bsa_pkg.sv]
// Shared constants, codes and types of the banker's safety allocator.
package bsa_pkg;

  localparam int unsigned NUM_CLIENTS_DEF = 5;
  localparam int unsigned NUM_TYPES_DEF   = 3;
  localparam int unsigned COUNT_BITS_DEF  = 8;

  localparam int unsigned MAX_TYPES   = 3;
  localparam int unsigned FIELD_BITS  = 8;
  localparam int unsigned INDEX_BITS  = 3;
  localparam int unsigned ACTION_BITS = 2;
  localparam int unsigned STATUS_BITS = 3;

  localparam logic [ACTION_BITS-1:0] ACT_LOAD    = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_SET     = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_REQUEST = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_WRITTEN = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_GRANTED = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_NEED    = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_AVAIL   = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_UNSAFE  = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_BADLOAD = 3'd5;

  typedef struct packed {
    logic fin;
    logic safe;
  } scan_stat_t;

endpackage

[design/bsa_req_if.sv]
// Request channel: action, client index, amounts and held counts.
interface bsa_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [bsa_pkg::ACTION_BITS-1:0]       action;
  logic [bsa_pkg::INDEX_BITS-1:0]        process_index;
  logic [bsa_pkg::FIELD_BITS-1:0]        amount_0;
  logic [bsa_pkg::FIELD_BITS-1:0]        amount_1;
  logic [bsa_pkg::FIELD_BITS-1:0]        amount_2;
  logic [bsa_pkg::FIELD_BITS-1:0]        held_0;
  logic [bsa_pkg::FIELD_BITS-1:0]        held_1;
  logic [bsa_pkg::FIELD_BITS-1:0]        held_2;

  modport source (
    output valid, action, process_index, amount_0, amount_1, amount_2,
           held_0, held_1, held_2,
    input  ready
  );
  modport sink (
    input  valid, action, process_index, amount_0, amount_1, amount_2,
           held_0, held_1, held_2,
    output ready
  );
endinterface

[design/bsa_rsp_if.sv]
// Response channel: status code and grant flag.
interface bsa_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [bsa_pkg::STATUS_BITS-1:0] status;
  logic                            granted;

  modport source (output valid, status, granted, input ready);
  modport sink   (input valid, status, granted, output ready);
endinterface

[design/bsa_row_mem.sv]
// Client row memory: need and allocation per client, registered read, write forwarding.
module bsa_row_mem #(
  parameter int unsigned NUM_CLIENTS = bsa_pkg::NUM_CLIENTS_DEF,
  parameter int unsigned NUM_TYPES   = bsa_pkg::NUM_TYPES_DEF,
  parameter int unsigned COUNT_BITS  = bsa_pkg::COUNT_BITS_DEF,
  parameter int unsigned CLIENT_BITS = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  rd_en,
  input  logic [CLIENT_BITS-1:0]                rd_addr,
  input  logic                                  wr_en,
  input  logic [CLIENT_BITS-1:0]                wr_addr,
  input  logic [NUM_TYPES-1:0][COUNT_BITS-1:0]  wr_need,
  input  logic [NUM_TYPES-1:0][COUNT_BITS-1:0]  wr_alloc,
  output logic [NUM_TYPES-1:0][COUNT_BITS-1:0]  rd_need,
  output logic [NUM_TYPES-1:0][COUNT_BITS-1:0]  rd_alloc
);

  localparam int unsigned ROW_BITS = 2 * NUM_TYPES * COUNT_BITS;

  logic [ROW_BITS-1:0]    mem [NUM_CLIENTS];
  logic [NUM_CLIENTS-1:0] row_valid;
  logic [ROW_BITS-1:0]    rd_data;
  logic                   rd_live;
  logic                   same_row;

  assign same_row = wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_need, wr_alloc};
    end
    if (rd_en) begin
      // forward a write to the row being read
      if (same_row) begin
        rd_data <= {wr_need, wr_alloc};
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_live   <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_live <= same_row || row_valid[rd_addr];
      end
    end
  end

  // a row never written reads as zero
  assign rd_need  = rd_live ? rd_data[ROW_BITS-1:ROW_BITS/2] : '0;
  assign rd_alloc = rd_live ? rd_data[ROW_BITS/2-1:0] : '0;

  a_forward: assert property (@(posedge clk) disable iff (rst)
    (rd_en && same_row) |=> (rd_need == $past(wr_need) && rd_alloc == $past(wr_alloc)))
    else $error("row memory forwarding lost a write");

endmodule

[design/bsa_scan.sv]
// Safety scan: walks client rows cyclically until all finish or a full lap makes no progress.
module bsa_scan #(
  parameter int unsigned NUM_CLIENTS = bsa_pkg::NUM_CLIENTS_DEF,
  parameter int unsigned NUM_TYPES   = bsa_pkg::NUM_TYPES_DEF,
  parameter int unsigned COUNT_BITS  = bsa_pkg::COUNT_BITS_DEF,
  parameter int unsigned CLIENT_BITS = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [NUM_TYPES-1:0][COUNT_BITS-1:0]  start_avail,
  input  logic [NUM_TYPES-1:0][COUNT_BITS-1:0]  rd_need,
  input  logic [NUM_TYPES-1:0][COUNT_BITS-1:0]  rd_alloc,
  output logic                                  rd_en,
  output logic [CLIENT_BITS-1:0]                rd_addr,
  output bsa_pkg::scan_stat_t                   stat
);

  localparam int unsigned EXT_BITS   = $clog2(NUM_CLIENTS + 1);
  localparam int unsigned WORK_BITS  = COUNT_BITS + EXT_BITS;
  localparam int unsigned STALE_BITS = $clog2(NUM_CLIENTS + 1);
  localparam logic [CLIENT_BITS-1:0] LAST_CLIENT = CLIENT_BITS'(NUM_CLIENTS - 1);
  localparam logic [STALE_BITS-1:0]  STALE_LAST  = STALE_BITS'(NUM_CLIENTS - 1);

  logic                                 busy;
  logic                                 pend;
  logic [CLIENT_BITS-1:0]               ptr;
  logic [CLIENT_BITS-1:0]               eval_idx;
  logic [STALE_BITS-1:0]                stale;
  logic [NUM_CLIENTS-1:0]               done;
  logic [NUM_CLIENTS-1:0]               done_set;
  logic [NUM_TYPES-1:0][WORK_BITS-1:0]  work;
  logic [NUM_TYPES-1:0][WORK_BITS-1:0]  work_sum;
  logic                                 fits;
  logic                                 finish_safe;
  logic                                 finish_unsafe;
  logic                                 fin;
  logic                                 safe;

  assign rd_en   = busy;
  assign rd_addr = ptr;
  assign stat    = '{fin: fin, safe: safe};

  always_comb begin
    fits     = !done[eval_idx];
    done_set = done;
    done_set[eval_idx] = 1'b1;
    for (int t = 0; t < NUM_TYPES; t++) begin
      if ({{EXT_BITS{1'b0}}, rd_need[t]} > work[t]) begin
        fits = 1'b0;
      end
      work_sum[t] = work[t] + {{EXT_BITS{1'b0}}, rd_alloc[t]};
    end
    finish_safe   = pend && fits && (&done_set);
    finish_unsafe = pend && !fits && (stale == STALE_LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      pend  <= 1'b0;
      fin   <= 1'b0;
      safe  <= 1'b0;
      ptr   <= '0;
      stale <= '0;
      done  <= '0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        pend  <= 1'b0;
        ptr   <= '0;
        stale <= '0;
        done  <= '0;
      end else if (busy) begin
        // read the next row while the previous one is evaluated
        pend     <= 1'b1;
        ptr      <= (ptr == LAST_CLIENT) ? '0 : ptr + 1'b1;
        if (pend) begin
          if (fits) begin
            done  <= done_set;
            stale <= '0;
          end else begin
            stale <= stale + 1'b1;
          end
        end
        if (finish_safe || finish_unsafe) begin
          busy <= 1'b0;
          pend <= 1'b0;
          fin  <= 1'b1;
          safe <= finish_safe;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      eval_idx <= ptr;
    end
    if (start) begin
      for (int t = 0; t < NUM_TYPES; t++) begin
        work[t] <= {{EXT_BITS{1'b0}}, start_avail[t]};
      end
    end else if (busy && pend && fits) begin
      work <= work_sum;
    end
  end

  a_stale_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (stale < STALE_BITS'(NUM_CLIENTS)))
    else $error("safety scan ran a full lap without stopping");

endmodule

[design/bankers_safety_allocator.sv]
// Top level: request sequencer, available vector, client row memory, safety scan, output register.
// Sequence: load, set, undefined and out-of-range requests go from EXEC to REPLY; requests over
//   need or over available go through CHECK as well; a request that passes CHECK runs the safety
//   scan in SCAN over the client rows before REPLY.
// Throughput: one item at a time; ready returns in the same cycle as the registered result goes valid.
// Reset: rst clears the available vector, the row valid bits and all control state.
module bankers_safety_allocator #(
  parameter int unsigned NUM_CLIENTS = bsa_pkg::NUM_CLIENTS_DEF,
  parameter int unsigned NUM_TYPES   = bsa_pkg::NUM_TYPES_DEF,
  parameter int unsigned COUNT_BITS  = bsa_pkg::COUNT_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  bsa_req_if.sink        req,
  bsa_rsp_if.source      rsp
);

  localparam int unsigned CLIENT_BITS = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int unsigned LIM_BITS    = bsa_pkg::INDEX_BITS + 2;
  localparam int unsigned FB          = bsa_pkg::FIELD_BITS;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_CHECK = 5'b00100,
    S_SCAN  = 5'b01000,
    S_REPLY = 5'b10000
  } state_t;

  typedef logic [NUM_TYPES-1:0][COUNT_BITS-1:0] vec_t;

  state_t                                state;
  state_t                                state_next;
  logic [bsa_pkg::MAX_TYPES-1:0][FB-1:0] amt_field;
  logic [bsa_pkg::MAX_TYPES-1:0][FB-1:0] held_field;
  vec_t                                  amt_in;
  vec_t                                  held_in;
  logic [bsa_pkg::ACTION_BITS-1:0]       act;
  logic [bsa_pkg::INDEX_BITS-1:0]        who;
  vec_t                                  amt;
  vec_t                                  held;
  vec_t                                  avail;
  vec_t                                  orig_need;
  vec_t                                  orig_alloc;
  logic [bsa_pkg::STATUS_BITS-1:0]       st;
  logic                                  rsp_valid;
  logic [bsa_pkg::STATUS_BITS-1:0]       rsp_status;
  logic                                  rsp_granted;
  logic                                  accept;
  logic                                  reply_load;
  logic                                  who_ok;
  logic [CLIENT_BITS+bsa_pkg::INDEX_BITS-1:0] who_ext;
  logic [CLIENT_BITS-1:0]                who_addr;
  logic                                  held_ok;
  logic                                  need_ok;
  logic                                  avail_ok;
  vec_t                                  load_need;
  vec_t                                  need_less;
  vec_t                                  alloc_more;
  vec_t                                  avail_less;
  vec_t                                  avail_more;
  logic                                  mem_rd_en;
  logic [CLIENT_BITS-1:0]                mem_rd_addr;
  logic                                  wr_en;
  vec_t                                  wr_need;
  vec_t                                  wr_alloc;
  vec_t                                  mem_need;
  vec_t                                  mem_alloc;
  logic                                  scan_start;
  logic                                  scan_rd_en;
  logic [CLIENT_BITS-1:0]                scan_rd_addr;
  bsa_pkg::scan_stat_t                   scan_stat;

  assign amt_field[0]  = req.amount_0;
  assign amt_field[1]  = req.amount_1;
  assign amt_field[2]  = req.amount_2;
  assign held_field[0] = req.held_0;
  assign held_field[1] = req.held_1;
  assign held_field[2] = req.held_2;

  // mask or widen each field to the count width
  for (genvar t = 0; t < NUM_TYPES; t++) begin : g_field
    logic [COUNT_BITS+FB-1:0] amt_ext;
    logic [COUNT_BITS+FB-1:0] held_ext;
    assign amt_ext    = {{COUNT_BITS{1'b0}}, amt_field[t]};
    assign held_ext   = {{COUNT_BITS{1'b0}}, held_field[t]};
    assign amt_in[t]  = amt_ext[COUNT_BITS-1:0];
    assign held_in[t] = held_ext[COUNT_BITS-1:0];
  end

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  assign who_ok   = {2'b00, who} < LIM_BITS'(NUM_CLIENTS);
  assign who_ext  = {{CLIENT_BITS{1'b0}}, who};
  assign who_addr = who_ext[CLIENT_BITS-1:0];

  assign reply_load = (state == S_REPLY) && (!rsp_valid || rsp.ready);

  always_comb begin
    held_ok  = 1'b1;
    need_ok  = 1'b1;
    avail_ok = 1'b1;
    for (int t = 0; t < NUM_TYPES; t++) begin
      if (held[t] > amt[t]) begin
        held_ok = 1'b0;
      end
      if (amt[t] > mem_need[t]) begin
        need_ok = 1'b0;
      end
      if (amt[t] > avail[t]) begin
        avail_ok = 1'b0;
      end
      load_need[t]  = amt[t] - held[t];
      need_less[t]  = mem_need[t] - amt[t];
      alloc_more[t] = mem_alloc[t] + amt[t];
      avail_less[t] = avail[t] - amt[t];
      avail_more[t] = avail[t] + amt[t];
    end
  end

  // row memory write port selection
  always_comb begin
    wr_en    = 1'b0;
    wr_need  = load_need;
    wr_alloc = held;
    case (state)
      S_EXEC: begin
        wr_en = (act == bsa_pkg::ACT_LOAD) && who_ok && held_ok;
      end
      S_CHECK: begin
        wr_en    = need_ok && avail_ok;
        wr_need  = need_less;
        wr_alloc = alloc_more;
      end
      S_SCAN: begin
        // roll back the tentative allocation
        wr_en    = scan_stat.fin && !scan_stat.safe;
        wr_need  = orig_need;
        wr_alloc = orig_alloc;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign mem_rd_en   = ((state == S_EXEC) && (act == bsa_pkg::ACT_REQUEST) && who_ok)
                       || scan_rd_en;
  assign mem_rd_addr = (state == S_SCAN) ? scan_rd_addr : who_addr;
  assign scan_start  = (state == S_CHECK) && need_ok && avail_ok;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if ((act == bsa_pkg::ACT_REQUEST) && who_ok) begin
          state_next = S_CHECK;
        end else begin
          state_next = S_REPLY;
        end
      end
      S_CHECK: begin
        state_next = scan_start ? S_SCAN : S_REPLY;
      end
      S_SCAN: begin
        if (scan_stat.fin) begin
          state_next = S_REPLY;
        end
      end
      S_REPLY: begin
        if (reply_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      avail     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_EXEC) && (act == bsa_pkg::ACT_SET)) begin
        avail <= amt;
      end else if (scan_start) begin
        avail <= avail_less;
      end else if ((state == S_SCAN) && scan_stat.fin && !scan_stat.safe) begin
        avail <= avail_more;
      end
      if (reply_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act  <= req.action;
      who  <= req.process_index;
      amt  <= amt_in;
      held <= held_in;
    end
    case (state)
      S_EXEC: begin
        case (act)
          bsa_pkg::ACT_LOAD:    st <= (who_ok && held_ok) ? bsa_pkg::ST_WRITTEN
                                                          : bsa_pkg::ST_BADLOAD;
          bsa_pkg::ACT_SET:     st <= bsa_pkg::ST_WRITTEN;
          bsa_pkg::ACT_REQUEST: st <= bsa_pkg::ST_NEED;
          default:              st <= bsa_pkg::ST_BADLOAD;
        endcase
      end
      S_CHECK: begin
        orig_need  <= mem_need;
        orig_alloc <= mem_alloc;
        if (!need_ok) begin
          st <= bsa_pkg::ST_NEED;
        end else if (!avail_ok) begin
          st <= bsa_pkg::ST_AVAIL;
        end
      end
      S_SCAN: begin
        if (scan_stat.fin) begin
          st <= scan_stat.safe ? bsa_pkg::ST_GRANTED : bsa_pkg::ST_UNSAFE;
        end
      end
      default: begin
        st <= st;
      end
    endcase
    if (reply_load) begin
      rsp_status  <= st;
      rsp_granted <= (st == bsa_pkg::ST_GRANTED);
    end
  end

  assign rsp.valid   = rsp_valid;
  assign rsp.status  = rsp_status;
  assign rsp.granted = rsp_granted;

  bsa_row_mem #(
    .NUM_CLIENTS (NUM_CLIENTS),
    .NUM_TYPES   (NUM_TYPES),
    .COUNT_BITS  (COUNT_BITS),
    .CLIENT_BITS (CLIENT_BITS)
  ) u_row_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (mem_rd_en),
    .rd_addr  (mem_rd_addr),
    .wr_en    (wr_en),
    .wr_addr  (who_addr),
    .wr_need  (wr_need),
    .wr_alloc (wr_alloc),
    .rd_need  (mem_need),
    .rd_alloc (mem_alloc)
  );

  bsa_scan #(
    .NUM_CLIENTS (NUM_CLIENTS),
    .NUM_TYPES   (NUM_TYPES),
    .COUNT_BITS  (COUNT_BITS),
    .CLIENT_BITS (CLIENT_BITS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (scan_start),
    .start_avail (avail_less),
    .rd_need     (mem_need),
    .rd_alloc    (mem_alloc),
    .rd_en       (scan_rd_en),
    .rd_addr     (scan_rd_addr),
    .stat        (scan_stat)
  );

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && !scan_stat.fin) |-> !wr_en)
    else $error("row write while the safety scan reads the table");

  a_scan_holds: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && !scan_stat.fin) |=> (state == S_SCAN))
    else $error("sequencer left the scan before it finished");

  a_grant_code: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_granted) |-> (rsp_status == bsa_pkg::ST_GRANTED))
    else $error("grant flag without granted status");

endmodule
